/* rtl/core/spq_pkg.sv */
// Shared types and constants for the sorted priority queue core.
package spq_pkg;

   localparam int SPQ_MAX_ENTRIES = 16;
   localparam int SPQ_ITEM_W      = 32;
   localparam int SPQ_PRIO_W      = 8;
   localparam int SPQ_CAP_W       = 5;
   localparam logic [SPQ_CAP_W-1:0] SPQ_CAP_RESET = 5'd16;

   // Operation code carried in tuser of the request channel
   typedef enum logic {
      KIND_ENQUEUE = 1'b0,
      KIND_DEQUEUE = 1'b1
   } kind_type;

   // Result code carried in tuser of the response channel
   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_FULL     = 2'd1,
      ST_DEQUEUED = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // One stored entry
   typedef struct packed {
      logic signed [SPQ_ITEM_W-1:0] item;
      logic [SPQ_PRIO_W-1:0]        prio;
   } entry_type;

   // Operation broadcast to every cell of the row
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type fresh;
   } cmd_type;

endpackage

/* rtl/core/sorted_priority_queue_core.sv */
// Top level of the sorted priority queue: a row of shifting cells plus a response register.
//
//  channel | direction | tdata (low bit up)                 | tuser
//  req_    | in        | item[31:0], priority_req[39:32]    | kind (0 enqueue, 1 dequeue)
//  rsp_    | out       | item_out[31:0], priority_out[39:32]| status[1:0]
//  csr_    | in        | csr_wdata: capacity[4:0]           | -
//
// Each transaction is resolved in the cycle it is accepted: every cell compares its own
// priority with the new one and the whole row shifts at once, so one transaction per cycle
// unless the response stalls. The response register is the only stage; a request is taken
// whenever it is empty or being drained in the same cycle; the result shows in the next cycle.
// Reset clears occupancy, the response valid flag and sets capacity to 16.
// A stalled response holds the queue: no request is taken until it is drained.
module sorted_priority_queue_core
   import spq_pkg::*;
#(
   parameter int MAX_ENTRIES = SPQ_MAX_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   // request: tdata = item[31:0], priority_req[39:32]; tuser = kind
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [39:0]          req_tdata,
   input  logic                 req_tuser,
   // response: tdata = item_out[31:0], priority_out[39:32]; tuser = status[1:0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,
   output logic [1:0]           rsp_tuser,
   // capacity register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [SPQ_CAP_W-1:0] csr_wdata
);

   localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (OCC_W > SPQ_CAP_W) ? OCC_W : SPQ_CAP_W;

   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [SPQ_CAP_W-1:0] cap_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   entry_type            out_ff, out_in;

   logic      accept;
   logic      full;
   logic      empty;
   kind_type  kind;
   cmd_type   cmd;

   entry_type cell_entry [MAX_ENTRIES];
   logic      cell_behind [MAX_ENTRIES];

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);

   assign full  = (occ_ff >= OCC_W'(MAX_ENTRIES))
                  || (CMP_W'(occ_ff) >= CMP_W'(cap_ff));
   assign empty = (occ_ff == '0);

   always_comb begin
      cmd.enq        = accept && (kind == KIND_ENQUEUE) && !full;
      cmd.deq        = accept && (kind == KIND_DEQUEUE) && !empty;
      cmd.fresh.item = req_tdata[31:0];
      cmd.fresh.prio = req_tdata[39:32];
   end

   // Row of cells: front of the queue at cell 0
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic      prev_behind;
      entry_type prev_entry;
      entry_type next_entry;

      if (i == 0) begin : g_head
         assign prev_behind = 1'b0;
         assign prev_entry  = cell_entry[i];
      end else begin : g_body
         assign prev_behind = cell_behind[i-1];
         assign prev_entry  = cell_entry[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign next_entry = cell_entry[i];
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (OCC_W'(i) < occ_ff),
         .prev_behind (prev_behind),
         .prev_entry  (prev_entry),
         .next_entry  (next_entry),
         .behind      (cell_behind[i]),
         .entry       (cell_entry[i])
      );
   end

   // Occupancy: advance on a stored enqueue, drop on a served dequeue
   always_comb begin
      occ_in = occ_ff;
      if (cmd.enq) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (cmd.deq) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   // Response register: load on accept, clear once drained
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      out_in       = out_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_in       = '0;
         unique case (kind)
            KIND_ENQUEUE: status_in = full ? ST_FULL : ST_ENQUEUED;
            KIND_DEQUEUE: begin
               status_in = empty ? ST_EMPTY : ST_DEQUEUED;
               if (!empty) begin
                  out_in = cell_entry[0];
               end
            end
            default: status_in = ST_ENQUEUED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         cap_ff       <= SPQ_CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {out_ff.prio, out_ff.item};

endmodule

/* rtl/core/spq_cell.sv */
// One slot of the sorted row: holds an entry and shifts with its neighbours.
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  cmd_type   cmd,
   input  logic      occupied,
   input  logic      prev_behind,
   input  entry_type prev_entry,
   input  entry_type next_entry,
   output logic      behind,
   output entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // The new entry goes ahead of this one when the slot is empty or holds an equal or
   // greater priority value.
   assign behind = !occupied || (entry_ff.prio >= cmd.fresh.prio);
   assign entry  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq) begin
         if (prev_behind) begin
            entry_in = prev_entry;
         end else if (behind) begin
            entry_in = cmd.fresh;
         end
      end else if (cmd.deq) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
